>>> rtl/ncrf_pkg.sv
// Shared types, constants and helper functions for the cubic root finder.
// Used by the divider, the datapath, the controller and the top level.
package ncrf_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS = 24;
	localparam int DIV_WIDTH = DATA_WIDTH + FRAC_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_WIDTH + 1);
	localparam int COUNT_W = 8;
	localparam int TOL_W = 31;
	localparam int UPC_W = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;

	typedef logic signed [DATA_WIDTH-1:0] fx_t;
	typedef logic [DATA_WIDTH-1:0] umag_t;

	localparam fx_t FX_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam fx_t FX_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	// Coefficients 0.1, 0.3 and 0.6, rounded to the nearest code.
	localparam longint C1_VAL = ((64'd1 << FRAC_BITS) + 64'd5) / 64'd10;
	localparam longint C3_VAL = ((64'd3 << FRAC_BITS) + 64'd5) / 64'd10;
	localparam longint C6_VAL = ((64'd6 << FRAC_BITS) + 64'd5) / 64'd10;
	localparam fx_t C_0P1 = fx_t'(C1_VAL);
	localparam fx_t C_0P3 = fx_t'(C3_VAL);
	localparam fx_t C_0P6 = fx_t'(C6_VAL);

	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(167772);
	localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(64);

	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 1'b1;

	localparam logic [1:0] STAT_CONVERGED = 2'd0;
	localparam logic [1:0] STAT_NO_ROOT = 2'd1;
	localparam logic [1:0] STAT_LIMIT = 2'd2;
	localparam logic [1:0] STAT_ZERO_DERIV = 2'd3;

	typedef struct packed {
		logic signed [31:0] lower_bound;
		logic signed [31:0] upper_bound;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] root;
		logic [7:0] iteration_count;
		logic [1:0] status;
	} out_item_t;

	typedef enum logic [2:0] {OP_NOP, OP_MUL, OP_RND, OP_ADD, OP_SUB} alu_op_t;
	typedef enum logic [2:0] {
		SRC_ZERO, SRC_X, SRC_X2, SRC_T, SRC_P, SRC_C1, SRC_C3, SRC_C6
	} src_t;
	typedef enum logic [2:0] {DST_NONE, DST_X2, DST_T, DST_P, DST_F, DST_D} dst_t;
	typedef enum logic [2:0] {XS_HOLD, XS_LO, XS_UP, XS_START, XS_NX} x_sel_t;
	typedef enum logic [2:0] {RES_CONV, RES_NOSIGN, RES_LIMIT, RES_DZERO, RES_MID} res_kind_t;

	typedef enum logic [3:0] {
		S_IDLE, S_XLO, S_EV_FLO, S_XUP, S_EV_FUP, S_D2, S_EV_D2, S_CHK,
		S_EV_D1, S_DCHK, S_EV_F, S_DIVGO, S_DIVWAIT, S_STEP, S_CONV, S_FINISH
	} state_t;

	typedef struct packed {
		alu_op_t op;
		src_t a_sel;
		src_t b_sel;
		dst_t dst;
		logic last;
	} uop_t;

	typedef struct packed {
		uop_t uop;
		x_sel_t x_sel;
		logic load_in;
		logic cap_flo;
		logic cap_fup;
		logic div_start;
		logic step;
		logic clr_count;
		logic pend_load;
		res_kind_t pend_kind;
		logic res_load;
	} cmd_t;

	typedef struct packed {
		logic no_sign;
		logic narrow;
		logic start_up;
		logic d_zero;
		logic conv;
		logic at_limit;
		logic div_busy;
		logic div_done;
	} stat_t;

	// Microcode entry points.
	localparam logic [UPC_W-1:0] UPC_F = UPC_W'(0);
	localparam logic [UPC_W-1:0] UPC_D1 = UPC_W'(11);
	localparam logic [UPC_W-1:0] UPC_D2 = UPC_W'(19);

	// f(x) = x^3 + 0.3x^2 - 0.6x - 0.1, f'(x) = 3x^2 + 0.6x - 0.6,
	// f''(x) = 6x + 0.6, each term saturated in the order given.
	function automatic uop_t ncrf_uop(input logic [UPC_W-1:0] pc);
		uop_t u;
		u = '{OP_NOP, SRC_ZERO, SRC_ZERO, DST_NONE, 1'b1};
		unique case (pc)
			5'd0: u = '{OP_MUL, SRC_X, SRC_X, DST_NONE, 1'b0};
			5'd1: u = '{OP_RND, SRC_ZERO, SRC_ZERO, DST_X2, 1'b0};
			5'd2: u = '{OP_MUL, SRC_X2, SRC_X, DST_NONE, 1'b0};
			5'd3: u = '{OP_RND, SRC_ZERO, SRC_ZERO, DST_T, 1'b0};
			5'd4: u = '{OP_MUL, SRC_C3, SRC_X2, DST_NONE, 1'b0};
			5'd5: u = '{OP_RND, SRC_ZERO, SRC_ZERO, DST_P, 1'b0};
			5'd6: u = '{OP_ADD, SRC_T, SRC_P, DST_T, 1'b0};
			5'd7: u = '{OP_MUL, SRC_C6, SRC_X, DST_NONE, 1'b0};
			5'd8: u = '{OP_RND, SRC_ZERO, SRC_ZERO, DST_P, 1'b0};
			5'd9: u = '{OP_SUB, SRC_T, SRC_P, DST_T, 1'b0};
			5'd10: u = '{OP_SUB, SRC_T, SRC_C1, DST_F, 1'b1};
			5'd11: u = '{OP_MUL, SRC_X, SRC_X, DST_NONE, 1'b0};
			5'd12: u = '{OP_RND, SRC_ZERO, SRC_ZERO, DST_X2, 1'b0};
			5'd13: u = '{OP_ADD, SRC_X2, SRC_X2, DST_T, 1'b0};
			5'd14: u = '{OP_ADD, SRC_T, SRC_X2, DST_T, 1'b0};
			5'd15: u = '{OP_MUL, SRC_C6, SRC_X, DST_NONE, 1'b0};
			5'd16: u = '{OP_RND, SRC_ZERO, SRC_ZERO, DST_P, 1'b0};
			5'd17: u = '{OP_ADD, SRC_T, SRC_P, DST_T, 1'b0};
			5'd18: u = '{OP_SUB, SRC_T, SRC_C6, DST_D, 1'b1};
			5'd19: u = '{OP_ADD, SRC_ZERO, SRC_X, DST_T, 1'b0};
			5'd20: u = '{OP_ADD, SRC_T, SRC_X, DST_T, 1'b0};
			5'd21: u = '{OP_ADD, SRC_T, SRC_X, DST_T, 1'b0};
			5'd22: u = '{OP_ADD, SRC_T, SRC_X, DST_T, 1'b0};
			5'd23: u = '{OP_ADD, SRC_T, SRC_X, DST_T, 1'b0};
			5'd24: u = '{OP_ADD, SRC_T, SRC_X, DST_T, 1'b0};
			5'd25: u = '{OP_ADD, SRC_T, SRC_C6, DST_D, 1'b1};
			default: u = '{OP_NOP, SRC_ZERO, SRC_ZERO, DST_NONE, 1'b1};
		endcase
		return u;
	endfunction

	function automatic umag_t ncrf_mag(input fx_t v);
		return v[DATA_WIDTH-1] ? umag_t'(-v) : umag_t'(v);
	endfunction

	function automatic fx_t ncrf_sat(input logic signed [DATA_WIDTH:0] v);
		if (v[DATA_WIDTH] != v[DATA_WIDTH-1]) begin
			return v[DATA_WIDTH] ? FX_MIN : FX_MAX;
		end
		return v[DATA_WIDTH-1:0];
	endfunction

	function automatic logic [DATA_WIDTH:0] ncrf_dist(input fx_t a, input fx_t b);
		logic signed [DATA_WIDTH:0] d;
		d = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
		return d[DATA_WIDTH] ? (DATA_WIDTH+1)'(-d) : (DATA_WIDTH+1)'(d);
	endfunction

endpackage

>>> rtl/ncrf_div.sv
// Sequential restoring divider for the Newton quotient, one bit per cycle.
// Depends on ncrf_pkg for widths, the magnitude helper and the saturation limits.
module ncrf_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  ncrf_pkg::fx_t num,
	input  ncrf_pkg::fx_t den,
	output logic busy,
	output logic done,
	output ncrf_pkg::fx_t quo
);

	logic [ncrf_pkg::DIV_WIDTH-1:0] work_q;
	logic [ncrf_pkg::DATA_WIDTH-1:0] rem_q;
	logic [ncrf_pkg::DATA_WIDTH-1:0] den_q;
	logic neg_q;
	logic [ncrf_pkg::DIV_CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	ncrf_pkg::fx_t quo_q;

	logic [ncrf_pkg::DATA_WIDTH:0] rem2;
	logic [ncrf_pkg::DATA_WIDTH:0] rem_sub;
	logic ge;
	logic [ncrf_pkg::DIV_WIDTH-1:0] lim;
	ncrf_pkg::fx_t quo_d;

	assign rem2 = {rem_q, work_q[ncrf_pkg::DIV_WIDTH-1]};
	assign ge = rem2 >= {1'b0, den_q};
	assign rem_sub = rem2 - {1'b0, den_q};

	// The quotient saturates toward the signed range, one code wider when negative.
	always_comb begin
		lim = ncrf_pkg::DIV_WIDTH'(ncrf_pkg::FX_MAX) + ncrf_pkg::DIV_WIDTH'(neg_q);
		if (work_q > lim) begin
			quo_d = neg_q ? ncrf_pkg::FX_MIN : ncrf_pkg::FX_MAX;
		end else if (neg_q) begin
			quo_d = -ncrf_pkg::fx_t'(work_q[ncrf_pkg::DATA_WIDTH-1:0]);
		end else begin
			quo_d = ncrf_pkg::fx_t'(work_q[ncrf_pkg::DATA_WIDTH-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= ncrf_pkg::DIV_CNT_W'(ncrf_pkg::DIV_WIDTH);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= {ncrf_pkg::ncrf_mag(num), {ncrf_pkg::FRAC_BITS{1'b0}}};
			rem_q <= '0;
			den_q <= ncrf_pkg::ncrf_mag(den);
			neg_q <= num[ncrf_pkg::DATA_WIDTH-1] ^ den[ncrf_pkg::DATA_WIDTH-1];
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				quo_q <= quo_d;
			end else begin
				rem_q <= ge ? rem_sub[ncrf_pkg::DATA_WIDTH-1:0] : rem2[ncrf_pkg::DATA_WIDTH-1:0];
				work_q <= {work_q[ncrf_pkg::DIV_WIDTH-2:0], ge};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo = quo_q;

endmodule

>>> rtl/ncrf_dp.sv
// Datapath: operand registers, a shared multiply/add unit, the divider,
// configuration registers and the result registers. Depends on ncrf_pkg, ncrf_div.
module ncrf_dp (
	input  logic clk,
	input  logic arst_n,
	input  ncrf_pkg::cmd_t cmd,
	output ncrf_pkg::stat_t stat,
	input  ncrf_pkg::in_item_t in_data,
	input  logic cfg_we,
	input  logic [ncrf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ncrf_pkg::CFG_DATA_W-1:0] cfg_data,
	output ncrf_pkg::out_item_t out_data
);

	ncrf_pkg::fx_t lo_q, up_q, x_q, x2_q, t_q, p_q, f_q, d_q, nx_q;
	logic flo_neg_q, flo_zero_q, fup_neg_q, fup_zero_q;
	logic [ncrf_pkg::COUNT_W-1:0] cnt_q;
	logic [ncrf_pkg::TOL_W-1:0] tol_q;
	logic [ncrf_pkg::COUNT_W-1:0] lim_q;
	logic [2*ncrf_pkg::DATA_WIDTH-1:0] prod_s1;
	logic pneg_s1;
	ncrf_pkg::fx_t pend_root_q;
	logic [ncrf_pkg::COUNT_W-1:0] pend_cnt_q;
	logic [1:0] pend_stat_q;
	ncrf_pkg::out_item_t res_q;

	ncrf_pkg::fx_t opa, opb, alu_res, quo, mid;
	logic [2*ncrf_pkg::DATA_WIDTH:0] rsum;
	logic [2*ncrf_pkg::DATA_WIDTH-ncrf_pkg::FRAC_BITS:0] rsh;
	logic [2*ncrf_pkg::DATA_WIDTH-ncrf_pkg::FRAC_BITS:0] rlim;
	logic signed [ncrf_pkg::DATA_WIDTH:0] sum_w;
	logic [ncrf_pkg::COUNT_W-1:0] lim_eff;
	logic div_busy, div_done;

	function automatic ncrf_pkg::fx_t pick(input ncrf_pkg::src_t s, input ncrf_pkg::fx_t x,
			input ncrf_pkg::fx_t x2, input ncrf_pkg::fx_t t, input ncrf_pkg::fx_t p);
		ncrf_pkg::fx_t v;
		case (s)
			ncrf_pkg::SRC_X: v = x;
			ncrf_pkg::SRC_X2: v = x2;
			ncrf_pkg::SRC_T: v = t;
			ncrf_pkg::SRC_P: v = p;
			ncrf_pkg::SRC_C1: v = ncrf_pkg::C_0P1;
			ncrf_pkg::SRC_C3: v = ncrf_pkg::C_0P3;
			ncrf_pkg::SRC_C6: v = ncrf_pkg::C_0P6;
			default: v = '0;
		endcase
		return v;
	endfunction

	assign opa = pick(cmd.uop.a_sel, x_q, x2_q, t_q, p_q);
	assign opb = pick(cmd.uop.b_sel, x_q, x2_q, t_q, p_q);

	// Rounding of the staged product (add half an LSB, drop the fraction, saturate), and saturating add/subtract.
	always_comb begin
		rsum = {1'b0, prod_s1} + ((2*ncrf_pkg::DATA_WIDTH+1)'(1) << (ncrf_pkg::FRAC_BITS - 1));
		rsh = rsum[2*ncrf_pkg::DATA_WIDTH:ncrf_pkg::FRAC_BITS];
		rlim = $bits(rlim)'(ncrf_pkg::FX_MAX) + $bits(rlim)'(pneg_s1);
		case (cmd.uop.op)
			ncrf_pkg::OP_RND: begin
				if (rsh > rlim) begin
					alu_res = pneg_s1 ? ncrf_pkg::FX_MIN : ncrf_pkg::FX_MAX;
				end else begin
					alu_res = pneg_s1 ? -ncrf_pkg::fx_t'(rsh[ncrf_pkg::DATA_WIDTH-1:0])
						: ncrf_pkg::fx_t'(rsh[ncrf_pkg::DATA_WIDTH-1:0]);
				end
			end
			ncrf_pkg::OP_ADD: alu_res = ncrf_pkg::ncrf_sat({opa[ncrf_pkg::DATA_WIDTH-1], opa}
				+ {opb[ncrf_pkg::DATA_WIDTH-1], opb});
			ncrf_pkg::OP_SUB: alu_res = ncrf_pkg::ncrf_sat({opa[ncrf_pkg::DATA_WIDTH-1], opa}
				- {opb[ncrf_pkg::DATA_WIDTH-1], opb});
			default: alu_res = '0;
		endcase
	end

	assign sum_w = {lo_q[ncrf_pkg::DATA_WIDTH-1], lo_q} + {up_q[ncrf_pkg::DATA_WIDTH-1], up_q};
	assign mid = sum_w[ncrf_pkg::DATA_WIDTH:1];
	assign lim_eff = (lim_q == '0) ? ncrf_pkg::COUNT_W'(1) : lim_q;

	ncrf_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.num(f_q),
		.den(d_q),
		.busy(div_busy),
		.done(div_done),
		.quo(quo)
	);

	always_comb begin
		stat.no_sign = flo_zero_q | fup_zero_q | (flo_neg_q == fup_neg_q);
		stat.narrow = ncrf_pkg::ncrf_dist(up_q, lo_q) < (ncrf_pkg::DATA_WIDTH+1)'(tol_q);
		stat.d_zero = (d_q == '0);
		stat.start_up = !fup_zero_q && !stat.d_zero && (fup_neg_q == d_q[ncrf_pkg::DATA_WIDTH-1]);
		stat.conv = ncrf_pkg::ncrf_dist(nx_q, x_q) < (ncrf_pkg::DATA_WIDTH+1)'(tol_q);
		stat.at_limit = cnt_q >= lim_eff;
		stat.div_busy = div_busy;
		stat.div_done = div_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= ncrf_pkg::TOL_RESET;
			lim_q <= ncrf_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ncrf_pkg::REG_TOLERANCE: tol_q <= cfg_data[ncrf_pkg::TOL_W-1:0];
				ncrf_pkg::REG_ITER_LIMIT: lim_q <= cfg_data[ncrf_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			lo_q <= in_data.lower_bound;
			up_q <= in_data.upper_bound;
		end
		case (cmd.x_sel)
			ncrf_pkg::XS_LO: x_q <= lo_q;
			ncrf_pkg::XS_UP: x_q <= up_q;
			ncrf_pkg::XS_START: x_q <= stat.start_up ? up_q : lo_q;
			ncrf_pkg::XS_NX: x_q <= nx_q;
			default: ;
		endcase
		if (cmd.uop.op == ncrf_pkg::OP_MUL) begin
			prod_s1 <= ncrf_pkg::ncrf_mag(opa) * ncrf_pkg::ncrf_mag(opb);
			pneg_s1 <= opa[ncrf_pkg::DATA_WIDTH-1] ^ opb[ncrf_pkg::DATA_WIDTH-1];
		end
		case (cmd.uop.dst)
			ncrf_pkg::DST_X2: x2_q <= alu_res;
			ncrf_pkg::DST_T: t_q <= alu_res;
			ncrf_pkg::DST_P: p_q <= alu_res;
			ncrf_pkg::DST_F: f_q <= alu_res;
			ncrf_pkg::DST_D: d_q <= alu_res;
			default: ;
		endcase
		if (cmd.cap_flo) begin
			flo_neg_q <= f_q[ncrf_pkg::DATA_WIDTH-1];
			flo_zero_q <= (f_q == '0);
		end
		if (cmd.cap_fup) begin
			fup_neg_q <= f_q[ncrf_pkg::DATA_WIDTH-1];
			fup_zero_q <= (f_q == '0);
		end
		if (cmd.clr_count) begin
			cnt_q <= '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.step) begin
			nx_q <= ncrf_pkg::ncrf_sat({x_q[ncrf_pkg::DATA_WIDTH-1], x_q}
				- {quo[ncrf_pkg::DATA_WIDTH-1], quo});
		end
		if (cmd.pend_load) begin
			case (cmd.pend_kind)
				ncrf_pkg::RES_CONV: begin
					pend_root_q <= nx_q;
					pend_cnt_q <= cnt_q;
					pend_stat_q <= ncrf_pkg::STAT_CONVERGED;
				end
				ncrf_pkg::RES_LIMIT: begin
					pend_root_q <= nx_q;
					pend_cnt_q <= cnt_q;
					pend_stat_q <= ncrf_pkg::STAT_LIMIT;
				end
				ncrf_pkg::RES_DZERO: begin
					pend_root_q <= x_q;
					pend_cnt_q <= cnt_q;
					pend_stat_q <= ncrf_pkg::STAT_ZERO_DERIV;
				end
				ncrf_pkg::RES_MID: begin
					pend_root_q <= mid;
					pend_cnt_q <= '0;
					pend_stat_q <= ncrf_pkg::STAT_CONVERGED;
				end
				default: begin
					pend_root_q <= '0;
					pend_cnt_q <= '0;
					pend_stat_q <= ncrf_pkg::STAT_NO_ROOT;
				end
			endcase
		end
		if (cmd.res_load) begin
			res_q.root <= pend_root_q;
			res_q.iteration_count <= pend_cnt_q;
			res_q.status <= pend_stat_q;
		end
	end

	assign out_data = res_q;

endmodule

>>> rtl/ncrf_ctrl.sv
// Controller: sequences the microcode routines for f, f' and f'', the divider
// and the Newton loop, and owns the input and output handshakes. Depends on ncrf_pkg.
module ncrf_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  ncrf_pkg::stat_t stat,
	output ncrf_pkg::cmd_t cmd
);

	ncrf_pkg::state_t state_q, state_d;
	logic [ncrf_pkg::UPC_W-1:0] pc_q, pc_d;
	logic out_valid_q;
	ncrf_pkg::uop_t uop;
	logic out_free;

	assign uop = ncrf_pkg::ncrf_uop(pc_q);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		pc_d = pc_q;
		unique case (state_q)
			ncrf_pkg::S_IDLE: if (in_valid) state_d = ncrf_pkg::S_XLO;
			ncrf_pkg::S_XLO: begin
				state_d = ncrf_pkg::S_EV_FLO;
				pc_d = ncrf_pkg::UPC_F;
			end
			ncrf_pkg::S_EV_FLO: begin
				pc_d = pc_q + 1'b1;
				if (uop.last) state_d = ncrf_pkg::S_XUP;
			end
			ncrf_pkg::S_XUP: begin
				state_d = ncrf_pkg::S_EV_FUP;
				pc_d = ncrf_pkg::UPC_F;
			end
			ncrf_pkg::S_EV_FUP: begin
				pc_d = pc_q + 1'b1;
				if (uop.last) state_d = ncrf_pkg::S_D2;
			end
			ncrf_pkg::S_D2: begin
				state_d = ncrf_pkg::S_EV_D2;
				pc_d = ncrf_pkg::UPC_D2;
			end
			ncrf_pkg::S_EV_D2: begin
				pc_d = pc_q + 1'b1;
				if (uop.last) state_d = ncrf_pkg::S_CHK;
			end
			ncrf_pkg::S_CHK: begin
				if (stat.no_sign || stat.narrow) begin
					state_d = ncrf_pkg::S_FINISH;
				end else begin
					state_d = ncrf_pkg::S_EV_D1;
					pc_d = ncrf_pkg::UPC_D1;
				end
			end
			ncrf_pkg::S_EV_D1: begin
				pc_d = pc_q + 1'b1;
				if (uop.last) state_d = ncrf_pkg::S_DCHK;
			end
			ncrf_pkg::S_DCHK: begin
				if (stat.d_zero) begin
					state_d = ncrf_pkg::S_FINISH;
				end else begin
					state_d = ncrf_pkg::S_EV_F;
					pc_d = ncrf_pkg::UPC_F;
				end
			end
			ncrf_pkg::S_EV_F: begin
				pc_d = pc_q + 1'b1;
				if (uop.last) state_d = ncrf_pkg::S_DIVGO;
			end
			ncrf_pkg::S_DIVGO: state_d = ncrf_pkg::S_DIVWAIT;
			ncrf_pkg::S_DIVWAIT: if (stat.div_done) state_d = ncrf_pkg::S_STEP;
			ncrf_pkg::S_STEP: state_d = ncrf_pkg::S_CONV;
			ncrf_pkg::S_CONV: begin
				if (stat.conv || stat.at_limit) begin
					state_d = ncrf_pkg::S_FINISH;
				end else begin
					state_d = ncrf_pkg::S_EV_D1;
					pc_d = ncrf_pkg::UPC_D1;
				end
			end
			ncrf_pkg::S_FINISH: if (out_free) state_d = ncrf_pkg::S_IDLE;
			default: state_d = ncrf_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.uop = '{ncrf_pkg::OP_NOP, ncrf_pkg::SRC_ZERO, ncrf_pkg::SRC_ZERO,
			ncrf_pkg::DST_NONE, 1'b0};
		cmd.x_sel = ncrf_pkg::XS_HOLD;
		cmd.pend_kind = ncrf_pkg::RES_NOSIGN;
		in_ready = 1'b0;
		unique case (state_q)
			ncrf_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.load_in = in_valid;
			end
			ncrf_pkg::S_XLO: cmd.x_sel = ncrf_pkg::XS_LO;
			ncrf_pkg::S_XUP: begin
				cmd.cap_flo = 1'b1;
				cmd.x_sel = ncrf_pkg::XS_UP;
			end
			ncrf_pkg::S_D2: cmd.cap_fup = 1'b1;
			ncrf_pkg::S_EV_FLO, ncrf_pkg::S_EV_FUP, ncrf_pkg::S_EV_D2,
			ncrf_pkg::S_EV_D1, ncrf_pkg::S_EV_F: cmd.uop = uop;
			ncrf_pkg::S_CHK: begin
				if (stat.no_sign) begin
					cmd.pend_load = 1'b1;
					cmd.pend_kind = ncrf_pkg::RES_NOSIGN;
				end else if (stat.narrow) begin
					cmd.pend_load = 1'b1;
					cmd.pend_kind = ncrf_pkg::RES_MID;
				end else begin
					cmd.x_sel = ncrf_pkg::XS_START;
					cmd.clr_count = 1'b1;
				end
			end
			ncrf_pkg::S_DCHK: begin
				cmd.pend_load = stat.d_zero;
				cmd.pend_kind = ncrf_pkg::RES_DZERO;
			end
			ncrf_pkg::S_DIVGO: cmd.div_start = 1'b1;
			ncrf_pkg::S_STEP: cmd.step = 1'b1;
			ncrf_pkg::S_CONV: begin
				if (stat.conv) begin
					cmd.pend_load = 1'b1;
					cmd.pend_kind = ncrf_pkg::RES_CONV;
				end else begin
					cmd.x_sel = ncrf_pkg::XS_NX;
					cmd.pend_load = stat.at_limit;
					cmd.pend_kind = ncrf_pkg::RES_LIMIT;
				end
			end
			ncrf_pkg::S_FINISH: cmd.res_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ncrf_pkg::S_IDLE;
			pc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pc_q <= pc_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !stat.div_busy)
		else $error("divider started while busy");
	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ncrf_pkg::S_XLO))
		else $error("accepted transaction did not start evaluation");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ncrf_pkg::S_DIVGO) |-> !stat.d_zero)
		else $error("division by zero derivative");
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> (state_q == ncrf_pkg::S_DIVWAIT))
		else $error("divider finished outside wait state");

endmodule

>>> rtl/newton_cubic_root_finder.sv
// Newton-Raphson root finder for x^3 + 0.3x^2 - 0.6x - 0.1 over an interval.
// Evaluation comes before the first Newton step; each step is mostly the wait on the
// one-bit-per-cycle divider and the microcoded evaluation. Transactions are handled
// one at a time: a new one is accepted once the last result has been loaded.
// Reset: asynchronous, active low; tolerance and iteration_limit return to defaults.
// Depends on ncrf_pkg, ncrf_ctrl, ncrf_dp.
module newton_cubic_root_finder (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  ncrf_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output ncrf_pkg::out_item_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [ncrf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ncrf_pkg::CFG_DATA_W-1:0] cfg_data
);

	ncrf_pkg::cmd_t cmd;
	ncrf_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	ncrf_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat(stat),
		.cmd(cmd)
	);

	ncrf_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.in_data(in_data),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_data(out_data)
	);

endmodule
